FILE: hdl/qvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_pkg
// Types, constants and the CORDIC arctangent table of the quad vertex
// transform, and a 32-bit saturation helper.
// ----------------------------------------------------------------------------
package qvt_pkg;

	localparam int NUM_VERTICES_DEF = 4;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN         = 24;

	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;
	localparam logic signed [34:0] DEG_Q7_TO_RAD   = 35'sd9595049034;

	typedef enum logic [1:0] {
		REQ_LOAD      = 2'd0,
		REQ_SCALE     = 2'd1,
		REQ_TRANSLATE = 2'd2,
		REQ_ROTATE    = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_RAD,
		ST_CORDIC,
		ST_FIX,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_MUL_D,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  vertex_index;
		logic [31:0] load_x;
		logic [31:0] load_y;
		logic [31:0] scale_factor;
		logic [31:0] shift_x;
		logic [31:0] shift_y;
		logic [16:0] angle_degrees;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_index;
		logic [31:0] vertex_x;
		logic [31:0] vertex_y;
		logic        last_vertex;
		logic        clipped;
	} out_item_t;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 32'sd843314857;
			5'd1:  atan_q30 = 32'sd497837829;
			5'd2:  atan_q30 = 32'sd263043837;
			5'd3:  atan_q30 = 32'sd133525159;
			5'd4:  atan_q30 = 32'sd67021687;
			5'd5:  atan_q30 = 32'sd33543516;
			5'd6:  atan_q30 = 32'sd16775851;
			5'd7:  atan_q30 = 32'sd8388437;
			5'd8:  atan_q30 = 32'sd4194283;
			5'd9:  atan_q30 = 32'sd2097149;
			5'd10: atan_q30 = 32'sd1048576;
			5'd11: atan_q30 = 32'sd524288;
			5'd12: atan_q30 = 32'sd262144;
			5'd13: atan_q30 = 32'sd131072;
			5'd14: atan_q30 = 32'sd65536;
			5'd15: atan_q30 = 32'sd32768;
			5'd16: atan_q30 = 32'sd16384;
			5'd17: atan_q30 = 32'sd8192;
			5'd18: atan_q30 = 32'sd4096;
			5'd19: atan_q30 = 32'sd2048;
			5'd20: atan_q30 = 32'sd1024;
			5'd21: atan_q30 = 32'sd512;
			5'd22: atan_q30 = 32'sd256;
			5'd23: atan_q30 = 32'sd128;
			default: atan_q30 = 32'sd0;
		endcase
	endfunction

	function automatic logic [31:0] sat32(input logic signed [47:0] v, output logic clip);
		clip = 1'b0;
		sat32 = v[31:0];
		if (v > 48'sd2147483647) begin
			clip = 1'b1;
			sat32 = 32'h7fff_ffff;
		end else if (v < -48'sd2147483648) begin
			clip = 1'b1;
			sat32 = 32'h8000_0000;
		end
	endfunction

endpackage : qvt_pkg
`default_nettype wire

FILE: hdl/qvt_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface qvt_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : qvt_stream_if
`default_nettype wire

FILE: hdl/quad_vertex_transform_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quad_vertex_transform_unit
// Scale, translate or rotate a stored polygon; emits every new vertex.
// ----------------------------------------------------------------------------
// Load: stores one vertex, no result. Scale: per vertex two products on the
// shared 34x34 multiplier, then sum and output; translate: sum and output.
// Rotate: angle reduction, CORDIC, a latch of cosine and sine, then per vertex
// four products, sum and output; output stalls add to the busy time.
// One request at a time; ready again the cycle after the last vertex is taken.
// Reset (arst_n low, asynchronous) clears the vertex store and the sequencer.
// ----------------------------------------------------------------------------
module quad_vertex_transform_unit #(
	parameter int NUM_VERTICES = qvt_pkg::NUM_VERTICES_DEF,
	parameter int CORDIC_STEPS = qvt_pkg::CORDIC_STEPS_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	qvt_stream_if.sink   req,
	qvt_stream_if.source rsp
);
	import qvt_pkg::*;

	localparam int IW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [31:0] vx_q [NUM_VERTICES];
	logic [31:0] vy_q [NUM_VERTICES];
	logic [IW-1:0] k_q;
	logic signed [16:0] a_q;
	logic neg_q;
	logic signed [33:0] rad_q, c_q, s_q;
	logic signed [31:0] px_q, py_q;
	logic signed [67:0] acc_x_q, acc_y_q;
	logic signed [67:0] prod;
	logic cstart, cdone;
	logic signed [33:0] cc, cs;
	out_item_t out_q;
	logic out_v_q;

	qvt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .angle(rad_q), .negate(neg_q),
		.done(cdone), .cos_val(cc), .sin_val(cs)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
	assign cstart    = (state_q == ST_RAD);

	logic signed [32:0] dx, dy;
	logic signed [31:0] cx, cy;
	always_comb begin
		cx = signed'(vx_q[k_q]);
		cy = signed'(vy_q[k_q]);
		dx = 33'(cx) - 33'(px_q);
		dy = 33'(cy) - 33'(py_q);
	end

	// shared multiplier: operands chosen by state
	logic signed [33:0] ma;
	logic signed [33:0] mb;
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_MUL_A: begin
				ma = (item_q.req_type == REQ_SCALE) ? 34'(cx) : 34'(dx);
				mb = (item_q.req_type == REQ_SCALE) ? 34'(signed'(item_q.scale_factor)) : c_q;
			end
			ST_MUL_B: begin
				ma = (item_q.req_type == REQ_SCALE) ? 34'(cy) : 34'(dy);
				mb = (item_q.req_type == REQ_SCALE) ? 34'(signed'(item_q.scale_factor)) : s_q;
			end
			ST_MUL_C: begin ma = 34'(dx); mb = s_q; end
			ST_MUL_D: begin ma = 34'(dy); mb = c_q; end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (req.valid) begin
				if (req_t'(req.data.req_type) == REQ_LOAD) state_d = ST_IDLE;
				else if (req_t'(req.data.req_type) == REQ_ROTATE) state_d = ST_ANGLE;
				else if (req_t'(req.data.req_type) == REQ_TRANSLATE) state_d = ST_SUM;
				else state_d = ST_MUL_A;
			end
			ST_ANGLE:  state_d = ST_RAD;
			ST_RAD:    state_d = ST_CORDIC;
			ST_CORDIC: if (cdone) state_d = ST_FIX;
			ST_FIX:    state_d = ST_MUL_A;
			ST_MUL_A:  state_d = ST_MUL_B;
			ST_MUL_B:  state_d = (item_q.req_type == REQ_SCALE) ? ST_SUM : ST_MUL_C;
			ST_MUL_C:  state_d = ST_MUL_D;
			ST_MUL_D:  state_d = ST_SUM;
			ST_SUM:    state_d = ST_OUT;
			ST_OUT: if (!out_v_q || rsp.ready) begin
				if (out_v_q && rsp.data.last_vertex) state_d = ST_IDLE;
				else if (!out_v_q) state_d = ST_OUT;
				else if (item_q.req_type == REQ_TRANSLATE) state_d = ST_SUM;
				else state_d = ST_MUL_A;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	logic signed [31:0] nxv, nyv;
	logic clx, cly;
	logic signed [47:0] nx48, ny48;
	logic signed [67:0] tx, ty;
	always_comb begin
		tx = acc_x_q;
		ty = acc_y_q;
		case (req_t'(item_q.req_type))
			REQ_SCALE: begin
				nx48 = 48'((acc_x_q + 68'sd32768) >>> 16);
				ny48 = 48'((acc_y_q + 68'sd32768) >>> 16);
			end
			REQ_TRANSLATE: begin
				nx48 = 48'(cx) + 48'(signed'(item_q.shift_x));
				ny48 = 48'(cy) + 48'(signed'(item_q.shift_y));
			end
			default: begin
				nx48 = 48'((tx + (68'sd1 <<< 28)) >>> 29) + 48'(px_q);
				ny48 = 48'((ty + (68'sd1 <<< 28)) >>> 29) + 48'(py_q);
			end
		endcase
		nxv = sat32(nx48, clx);
		nyv = sat32(ny48, cly);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			for (int i = 0; i < NUM_VERTICES; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
		end else begin
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			if (state_q == ST_IDLE && req.valid && req.data.req_type == REQ_LOAD
				&& 32'(req.data.vertex_index) < NUM_VERTICES) begin
				vx_q[IW'(req.data.vertex_index)] <= req.data.load_x;
				vy_q[IW'(req.data.vertex_index)] <= req.data.load_y;
			end
			if (state_q == ST_SUM) begin
				vx_q[k_q] <= nxv;
				vy_q[k_q] <= nyv;
				out_q.out_index   <= 2'(k_q);
				out_q.vertex_x    <= nxv;
				out_q.vertex_y    <= nyv;
				out_q.last_vertex <= (32'(k_q) == NUM_VERTICES - 1);
				out_q.clipped     <= clx | cly;
				out_v_q <= 1'b1;
			end
		end
	end

	logic signed [17:0] ar, a2, a3;
	always_comb begin
		ar = 18'(a_q);
		a2 = ar;
		if (ar > 18'sd23040) a2 = ar - 18'sd46080;
		a3 = a2;
		if (a2 > 18'sd11520) a3 = a2 - 18'sd23040;
		else if (a2 < -18'sd11520) a3 = a2 + 18'sd23040;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (req.valid) begin
				item_q <= req.data;
				k_q    <= '0;
				px_q   <= signed'(vx_q[0]);
				py_q   <= signed'(vy_q[0]);
				// fold into [0, 46080) by one subtraction or up to two additions; input range -65536 to 65535
				begin
					logic signed [17:0] t;
					t = 18'(signed'(req.data.angle_degrees));
					if (t >= 18'sd46080) t = t - 18'sd46080;
					else if (t < 18'sd0) t = t + 18'sd46080;
					if (t < 18'sd0) t = t + 18'sd46080;
					a_q <= 17'(t);
				end
			end
			ST_ANGLE: begin
				neg_q <= (a2 > 18'sd11520) || (a2 < -18'sd11520);
				a_q   <= 17'(a3);
			end
			ST_RAD: ;
			ST_FIX: begin
				c_q <= cc;
				s_q <= cs;
			end
			ST_MUL_A: begin
				if (item_q.req_type == REQ_SCALE) acc_x_q <= prod;
				else acc_x_q <= prod >>> 1;
			end
			ST_MUL_B: begin
				if (item_q.req_type == REQ_SCALE) acc_y_q <= prod;
				else acc_x_q <= acc_x_q - (prod >>> 1);
			end
			ST_MUL_C: acc_y_q <= prod >>> 1;
			ST_MUL_D: acc_y_q <= acc_y_q + (prod >>> 1);
			ST_OUT: if (out_v_q && rsp.ready) k_q <= k_q + IW'(1);
			default: ;
		endcase
	end

	always_comb prod = 68'(ma) * 68'(mb);

	always_ff @(posedge clk) begin
		if (state_q == ST_ANGLE)
			rad_q <= 34'((52'(signed'(a3)) * 52'(DEG_Q7_TO_RAD) + 52'sd32768) >>> 16);
	end
endmodule : quad_vertex_transform_unit
`default_nettype wire

FILE: hdl/qvt_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_cordic
// Iterative CORDIC in rotation mode: one micro-rotation per cycle, shared
// shifters and adders. Takes a Q4.30 angle, gives clamped cosine and sine.
// ----------------------------------------------------------------------------
module qvt_cordic #(
	parameter int CORDIC_STEPS = qvt_pkg::CORDIC_STEPS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire logic signed [33:0]  angle,
	input  wire                      negate,
	output logic                     done,
	output logic signed [33:0]       cos_val,
	output logic signed [33:0]       sin_val
);
	import qvt_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	logic signed [33:0] x_q, y_q, z_q, nx, ny, nz;
	logic [4:0]         i_q;
	logic               busy_q, neg_q;

	always_comb begin
		if (!z_q[33]) begin
			nx = x_q - (y_q >>> i_q);
			ny = y_q + (x_q >>> i_q);
			nz = z_q - 34'(atan_q30(i_q));
		end else begin
			nx = x_q + (y_q >>> i_q);
			ny = y_q - (x_q >>> i_q);
			nz = z_q + 34'(atan_q30(i_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN_INV;
			y_q   <= '0;
			z_q   <= angle;
			neg_q <= negate;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	logic signed [33:0] xf, yf;
	always_comb begin
		xf = neg_q ? -x_q : x_q;
		yf = neg_q ? -y_q : y_q;
		cos_val = (xf > Q30_ONE) ? Q30_ONE : ((xf < -Q30_ONE) ? -Q30_ONE : xf);
		sin_val = (yf > Q30_ONE) ? Q30_ONE : ((yf < -Q30_ONE) ? -Q30_ONE : yf);
	end
endmodule : qvt_cordic
`default_nettype wire

FILE: tb/quad_vertex_transform_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_vertex_transform_unit_tb
// Drives load, scale, translate and rotate requests through the valid/ready
// channels and compares every emitted vertex against a cycle-free predictor
// of the polygon store, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module quad_vertex_transform_unit_tb;
	import qvt_pkg::*;

	localparam int NV    = 4;
	localparam int STEPS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qvt_stream_if #(.T(in_item_t))  req_ch ();
	qvt_stream_if #(.T(out_item_t)) rsp_ch ();

	quad_vertex_transform_unit #(.NUM_VERTICES(NV), .CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic signed [31:0] poly_x [NV];
	logic signed [31:0] poly_y [NV];
	out_item_t          vertex_queue [$];

	int errors = 0;
	int n_sent = 0;
	int n_rsp = 0;
	int n_clip = 0;
	int send_idle_pct = 15;
	int recv_idle_pct = 60;
	bit recv_hold = 1'b0;

	function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [63:0] v, ref bit clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic sin_cos_q30(input logic signed [16:0] deg, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic signed [63:0] a, x, y, z, nx, at;
		bit flip;
		a = 64'(deg) % 46080;
		flip = 1'b0;
		if (a < 0) a += 46080;
		if (a > 23040) a -= 46080;
		if (a > 11520) begin
			a -= 23040;
			flip = 1'b1;
		end else if (a < -11520) begin
			a += 23040;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		z = floor_shr(a * 64'sd9595049034 + 32768, 16);
		for (int i = 0; i < STEPS && i < 24; i++) begin
			at = 64'(atan_q30(5'(i)));
			if (z >= 0) begin
				nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= at;
			end else begin
				nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += at;
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x > 64'sd1073741824 ? 64'sd1073741824 : (x < -64'sd1073741824 ? -64'sd1073741824 : x);
		s = y > 64'sd1073741824 ? 64'sd1073741824 : (y < -64'sd1073741824 ? -64'sd1073741824 : y);
	endtask

	task automatic predict_transform(input in_item_t it);
		logic signed [63:0] c, s, px, py, x, y, nx, ny, dx, dy, tx, ty, f;
		out_item_t o;
		bit clip;
		c = 0;
		s = 0;
		if (req_t'(it.req_type) == REQ_LOAD) begin
			poly_x[it.vertex_index] = it.load_x;
			poly_y[it.vertex_index] = it.load_y;
			return;
		end
		if (req_t'(it.req_type) == REQ_ROTATE) sin_cos_q30(it.angle_degrees, c, s);
		px = 64'(poly_x[0]);
		py = 64'(poly_y[0]);
		f = 64'($signed(it.scale_factor));
		for (int k = 0; k < NV; k++) begin
			x = 64'(poly_x[k]);
			y = 64'(poly_y[k]);
			clip = 1'b0;
			case (req_t'(it.req_type))
				REQ_SCALE: begin
					nx = floor_shr(x * f + 32768, 16);
					ny = floor_shr(y * f + 32768, 16);
				end
				REQ_TRANSLATE: begin
					nx = x + 64'($signed(it.shift_x));
					ny = y + 64'($signed(it.shift_y));
				end
				default: begin
					dx = x - px;
					dy = y - py;
					tx = floor_shr(c * dx, 1) - floor_shr(s * dy, 1);
					ty = floor_shr(s * dx, 1) + floor_shr(c * dy, 1);
					nx = floor_shr(tx + (64'sd1 <<< 28), 29) + px;
					ny = floor_shr(ty + (64'sd1 <<< 28), 29) + py;
				end
			endcase
			poly_x[k] = clip32(nx, clip);
			poly_y[k] = clip32(ny, clip);
			o.out_index   = 2'(k);
			o.vertex_x    = poly_x[k];
			o.vertex_y    = poly_y[k];
			o.last_vertex = (k == NV - 1);
			o.clipped     = clip;
			vertex_queue.push_back(o);
		end
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_rsp++;
			if (rsp_ch.data.clipped) n_clip++;
			if (vertex_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected vertex, actual %p", $time, rsp_ch.data);
			end else begin
				out_item_t e;
				e = vertex_queue.pop_front();
				if (rsp_ch.data !== e) begin
					errors++;
					$display("%0t: vertex mismatch, expected %p actual %p", $time, e, rsp_ch.data);
				end
			end
		end
	end

	// receiver ready, with its own long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic long_stall();
		recv_hold = 1'b1;
		repeat (400) @(posedge clk);
		recv_hold = 1'b0;
	endtask

	// valid stays up into the next request unless the sender idles first
	task automatic send_request(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.data  <= it;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		predict_transform(it);
		n_sent++;
	endtask

	function automatic in_item_t make_req(req_t r, logic [1:0] idx, logic [31:0] a,
			logic [31:0] b, logic [16:0] ang);
		in_item_t it;
		it = '{default: '0};
		it.req_type      = r;
		it.vertex_index  = idx;
		it.load_x        = a;
		it.load_y        = b;
		it.scale_factor  = a;
		it.shift_x       = a;
		it.shift_y       = b;
		it.angle_degrees = ang;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	function automatic in_item_t rand_req();
		in_item_t it;
		it = make_req(req_t'($urandom_range(3)), 2'($urandom_range(3)), rand_coord(),
			rand_coord(), 17'($signed($urandom_range(92160)) - 46080));
		// noise in load_x and angle_degrees, also where the request uses them
		if ($urandom_range(3) == 0) it.load_x = $urandom;
		if ($urandom_range(3) == 0) it.angle_degrees = 17'($urandom);
		if (req_t'(it.req_type) == REQ_SCALE && $urandom_range(2) != 0)
			it.scale_factor = 32'($signed($urandom_range(196608)) - 98304);
		return it;
	endfunction

	// directed rows; expected vertex 0 given where obvious, else predictor only
	typedef struct {
		in_item_t it;
		bit       known;
		logic [31:0] ex0;
		logic [31:0] ey0;
	} dir_row_t;

	dir_row_t dir_rows [$];

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		dir_rows = '{
			'{make_req(REQ_TRANSLATE, 0, 32'd0, 32'd0, 0), 1, 32'd0, 32'd0},
			'{make_req(REQ_SCALE, 0, 32'h0001_0000, 0, 0), 1, 32'd0, 32'd0},
			'{make_req(REQ_ROTATE, 0, 0, 0, 17'd11520), 1, 32'd0, 32'd0},
			'{make_req(REQ_LOAD, 0, 32'h0001_0000, 32'h0002_0000, 0), 0, 0, 0},
			'{make_req(REQ_LOAD, 1, 32'h7fff_ffff, 32'h8000_0000, 0), 0, 0, 0},
			'{make_req(REQ_LOAD, 2, 32'h8000_0000, 32'h7fff_ffff, 0), 0, 0, 0},
			'{make_req(REQ_LOAD, 3, 32'hffff_0000, 32'h0003_8000, 0), 0, 0, 0},
			'{make_req(REQ_TRANSLATE, 0, 32'h7fff_ffff, 32'h8000_0000, 0), 1,
				32'h7fff_ffff, 32'h8002_0000},
			'{make_req(REQ_LOAD, 0, 32'h0001_0000, 32'h0002_0000, 0), 0, 0, 0},
			'{make_req(REQ_SCALE, 0, 32'h7fff_ffff, 0, 0), 0, 0, 0},
			'{make_req(REQ_SCALE, 0, 32'h8000_0000, 0, 0), 0, 0, 0},
			'{make_req(REQ_LOAD, 1, 32'h0005_0000, 32'hfffd_0000, 0), 0, 0, 0},
			'{make_req(REQ_LOAD, 2, 32'h0010_0000, 32'h0, 0), 0, 0, 0},
			'{make_req(REQ_LOAD, 3, 32'h0, 32'h0010_0000, 0), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, 17'd46080), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, -17'sd46080), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, 17'd23040), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, -17'sd23040), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, 17'd11521), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, 17'h0ffff), 0, 0, 0},
			'{make_req(REQ_ROTATE, 0, 0, 0, 17'h10000), 0, 0, 0},
			'{make_req(REQ_SCALE, 0, 32'hffff_0000, 0, 0), 0, 0, 0},
			'{make_req(REQ_TRANSLATE, 0, 32'h8000_0000, 32'h7fff_ffff, 0), 0, 0, 0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].it);
			if (dir_rows[i].known && (vertex_queue[vertex_queue.size() - NV].vertex_x
					!== dir_rows[i].ex0 || vertex_queue[vertex_queue.size() - NV].vertex_y
					!== dir_rows[i].ey0)) begin
				errors++;
				$display("%0t: directed row %0d, expected %h %h actual %h %h", $time, i,
					dir_rows[i].ex0, dir_rows[i].ey0,
					vertex_queue[vertex_queue.size() - NV].vertex_x,
					vertex_queue[vertex_queue.size() - NV].vertex_y);
			end
		end

		// the receiver stalls long while requests keep coming
		fork
			long_stall();
			repeat (8) send_request(rand_req());
		join

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 15 : (phase == 1 ? 60 : 0);
			recv_idle_pct = (phase == 0) ? 60 : (phase == 1 ? 15 : 0);
			for (int n = 0; n < 63; n++) begin
				// in about one round of four a fresh polygon (moderate x, random y), then a transform
				if ($urandom_range(3) == 0) begin
					for (int v = 0; v < NV; v++)
						send_request(make_req(REQ_LOAD, 2'(v), 32'($signed($urandom_range(
							2000000)) - 1000000), 32'($urandom), 0));
				end
				send_request(rand_req());
			end
		end
		req_ch.valid <= 1'b0;

		while (vertex_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests, checked %0d vertices (%0d clipped).", n_sent, n_rsp,
			n_clip);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule : quad_vertex_transform_unit_tb
`default_nettype wire
